// ===== src/b64d_pkg.sv =====
// Package for the base64 stream decoder: character classes, the token and
// result structs, queue sizing and the byte count limit. No dependencies.

package b64d_pkg;

	// Byte count limit, held at the lesser of MAX_COUNT and the 16-bit range.
	localparam longint unsigned MAX_COUNT = 64'd65535;
	localparam logic [15:0] COUNT_CAP =
		(MAX_COUNT < 64'd65535) ? 16'(MAX_COUNT) : 16'hffff;

	// Token queue between the classifier and the decode back end.
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		K_SYM = 2'd0,
		K_WS  = 2'd1,
		K_PAD = 2'd2,
		K_BAD = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [5:0] value;
		logic       last;
	} tok_t;

	typedef struct packed {
		logic [15:0] byte_count;
		logic        bad_symbol;
		logic        done_res;
		logic        byte_valid;
		logic [7:0]  data_byte;
	} res_t;

	// Maps one ASCII code to its class and, for alphabet members, its 6-bit value.
	function automatic tok_t classify(input logic [7:0] c, input logic last);
		tok_t       t;
		logic [7:0] d;
		t.kind  = K_BAD;
		t.value = '0;
		t.last  = last;
		d       = '0;
		case (c) inside
			["A":"Z"]: begin
				d       = c - 8'h41;
				t.kind  = K_SYM;
				t.value = d[5:0];
			end
			["a":"z"]: begin
				d       = c - 8'h47;
				t.kind  = K_SYM;
				t.value = d[5:0];
			end
			["0":"9"]: begin
				d       = c + 8'h04;
				t.kind  = K_SYM;
				t.value = d[5:0];
			end
			8'h2b: begin
				t.kind  = K_SYM;
				t.value = 6'h3e;
			end
			8'h2f: begin
				t.kind  = K_SYM;
				t.value = 6'h3f;
			end
			8'h3d:                      t.kind = K_PAD;
			8'h20, 8'h09, 8'h0d, 8'h0a: t.kind = K_WS;
			default:                    t.kind = K_BAD;
		endcase
		return t;
	endfunction

endpackage

// ===== src/b64d_front.sv =====
// Front end: takes character beats and classifies each into a token.
// Depends on b64d_pkg.

module b64d_front import b64d_pkg::*; (
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tlast,
	input  logic       q_full,
	output logic       q_push,
	output tok_t       q_tok
);

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;
	assign q_tok    = classify(s_tdata, s_tlast);

endmodule

// ===== src/b64d_queue.sv =====
// Short token queue that decouples the classifier from the decode back end.
// Depends on b64d_pkg.

module b64d_queue import b64d_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tok_t push_tok,
	output logic full,
	input  logic pop,
	output logic empty,
	output tok_t head_tok
);

	tok_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(QDEPTH));
	assign empty    = (cnt_q == '0);
	assign head_tok = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("token queue count exceeds depth");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != QCNT_W'(QDEPTH)) |-> (QPTR_W'(wr_q - rd_q) == QPTR_W'(cnt_q)))
		else $error("token queue pointers disagree with count");
`endif

endmodule

// ===== src/b64d_back.sv =====
// Back end: runs the decode state on each token and holds the result beat.
// Depends on b64d_pkg.

module b64d_back import b64d_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  tok_t tok,
	output logic q_pop,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	logic [1:0]  phase_q, phase_n;
	logic [7:0]  partial_q, partial_n;
	logic        stopped_q, stopped_n;
	logic        error_q, error_n;
	logic [15:0] count_q, count_n;
	logic        have_byte;
	logic [7:0]  new_byte;
	logic        out_valid_q;
	res_t        out_q;
	logic        out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign q_pop     = !q_empty && out_free;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_comb begin
		phase_n   = phase_q;
		partial_n = partial_q;
		stopped_n = stopped_q;
		error_n   = error_q;
		have_byte = 1'b0;
		new_byte  = '0;
		if (!stopped_q && !error_q) begin
			case (tok.kind)
				K_PAD: stopped_n = 1'b1;
				K_BAD: error_n   = 1'b1;
				K_SYM: begin
					case (phase_q)
						2'd0: partial_n = {tok.value, 2'b00};
						2'd1: begin
							new_byte  = partial_q | {6'b0, tok.value[5:4]};
							partial_n = {tok.value[3:0], 4'b0};
							have_byte = 1'b1;
						end
						2'd2: begin
							new_byte  = partial_q | {4'b0, tok.value[5:2]};
							partial_n = {tok.value[1:0], 6'b0};
							have_byte = 1'b1;
						end
						default: begin
							new_byte  = partial_q | {2'b0, tok.value};
							partial_n = '0;
							have_byte = 1'b1;
						end
					endcase
					phase_n = phase_q + 2'd1;
				end
				default: ;
			endcase
		end
		count_n = (have_byte && (count_q < COUNT_CAP)) ? count_q + 16'd1 : count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			partial_q   <= '0;
			stopped_q   <= 1'b0;
			error_q     <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				if (tok.last) begin
					phase_q   <= '0;
					partial_q <= '0;
					stopped_q <= 1'b0;
					error_q   <= 1'b0;
					count_q   <= '0;
				end else begin
					phase_q   <= phase_n;
					partial_q <= partial_n;
					stopped_q <= stopped_n;
					error_q   <= error_n;
					count_q   <= count_n;
				end
			end
			if (out_free) begin
				out_valid_q <= q_pop && (have_byte || tok.last);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && q_pop) begin
			out_q.data_byte  <= new_byte;
			out_q.byte_valid <= have_byte;
			out_q.done_res   <= tok.last;
			out_q.bad_symbol <= tok.last && error_n;
			out_q.byte_count <= tok.last ? count_n : 16'd0;
		end
	end

`ifndef ASSERT_OFF
	a_status_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.done_res) |->
		(!out_q.bad_symbol && (out_q.byte_count == 16'd0)))
		else $error("status fields set on a beat that is not the message end");
	a_result_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.byte_valid || out_q.done_res))
		else $error("result beat carries neither a byte nor a done report");
	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && tok.last) |=>
		((phase_q == 2'd0) && !stopped_q && !error_q && (count_q == 16'd0)))
		else $error("decode state not cleared after message end");
`endif

endmodule

// ===== src/base64_stream_decoder_top.sv =====
// Base64 stream decoder top level. A character beat that is accepted passes
// through the token queue and then the result register before its result beat.
// Throughput: one character beat per cycle, sustained while the output is taken.
// Output stalls are absorbed by a four-entry token queue and the result register.
// Reset (arst_n low) clears the queue, the decode state and the result valid flag
// at once; no clearing pass is needed. Depends on b64d_pkg and the sub-modules.

module base64_stream_decoder_top import b64d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Input channel: one ASCII character per beat.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] symbol
	input  logic        s_tlast,   // end_of_message
	// Output channel: a decoded byte, a message-end report, or both.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] data_byte, [23:8] byte_count
	output logic [1:0]  m_tuser,   // [0] byte_valid, [1] bad_symbol
	output logic        m_tlast    // done_res
);

	// The front end classifies each character beat (alphabet symbol, whitespace,
	// padding or invalid) and writes a token to the queue. The back end pops a
	// token whenever its result register is free or being drained this cycle.
	logic q_full;
	logic q_push;
	tok_t q_tok;
	logic q_pop;
	logic q_empty;
	tok_t head_tok;
	res_t res;

	b64d_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_tok    (q_tok)
	);

	b64d_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_tok (q_tok),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head_tok (head_tok)
	);

	// The back end keeps the group phase, the partial byte, the padding and
	// error flags and the saturating byte count, and clears them after the
	// last character of a message.
	b64d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.tok       (head_tok),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {res.byte_count, res.data_byte};
	assign m_tuser = {res.bad_symbol, res.byte_valid};
	assign m_tlast = res.done_res;

endmodule
